@@ hw/rtl/ccu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccu_pkg - shared definitions for the complex coefficient update block
// Default word and fraction widths, lane counts and the pipeline control
// bundle passed from the top level to the lanes.
// ----------------------------------------------------------------------------
package ccu_pkg;

    // Width of every port field
    localparam int FIELD_W = 32;

    // Defaults for the top level parameters
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Three taps per row, six lanes (three rows by real and imaginary)
    localparam int NUM_TAPS  = 3;
    localparam int NUM_LANES = 6;

    // Stage enables shared by all lanes
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_pipe_ctrl;

endpackage

@@ hw/rtl/ccu_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccu_lane - one row-by-vector dot product lane
// Forms three fixed point products in parallel, registers them, then sums
// them and scales the sum by 0.75 into a registered coefficient delta.
// ----------------------------------------------------------------------------
module ccu_lane #(
    parameter int FRAC_BITS = ccu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = ccu_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  ccu_pkg::t_pipe_ctrl         i_ctrl,
    input  logic signed [WORD_BITS-1:0] i_row [ccu_pkg::NUM_TAPS],
    input  logic signed [WORD_BITS-1:0] i_err [ccu_pkg::NUM_TAPS],
    output logic signed [WORD_BITS-1:0] o_delta
);
    import ccu_pkg::*;

    logic signed [2*WORD_BITS-1:0] w_prod [NUM_TAPS];
    logic signed [WORD_BITS-1:0]   r_prod [NUM_TAPS];
    logic signed [WORD_BITS-1:0]   w_sum;
    logic signed [WORD_BITS-1:0]   n_delta;
    logic signed [WORD_BITS-1:0]   r_delta;

    // Multiply each tap, drop the fraction bits with a floor shift and wrap
    always_comb begin
        for (int j = 0; j < NUM_TAPS; j++) begin
            w_prod[j] = i_row[j] * i_err[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            for (int j = 0; j < NUM_TAPS; j++) begin
                r_prod[j] <= WORD_BITS'(w_prod[j] >>> FRAC_BITS);
            end
        end
    end

    // Sum the taps and scale by 0.75 as (x>>2)+(x>>1), all wrapping
    always_comb begin
        w_sum   = r_prod[0] + r_prod[1] + r_prod[2];
        n_delta = (w_sum >>> 2) + (w_sum >>> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sum) begin
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule

@@ hw/rtl/ccu_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccu_merge - coefficient store and result stage
// Adds the six lane deltas into the stored coefficients in one step and
// presents the updated set, sign-extended to the port width.
// ----------------------------------------------------------------------------
module ccu_merge #(
    parameter int WORD_BITS = ccu_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic signed [WORD_BITS-1:0]   i_delta [ccu_pkg::NUM_LANES],
    output logic [ccu_pkg::FIELD_W-1:0]   o_coef  [ccu_pkg::NUM_LANES]
);
    import ccu_pkg::*;

    logic signed [WORD_BITS-1:0] r_coef [NUM_LANES];

    // Accumulate deltas; clear the coefficients at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_load) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_coef[k] <= r_coef[k] + i_delta[k];
            end
        end
    end

    // Sign-extend to the port width
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            o_coef[k] = FIELD_W'(r_coef[k]);
        end
    end

endmodule

@@ hw/rtl/complex_coeff_update_3x3.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_coeff_update_3x3 - three-tap complex least-squares coefficient update
// Multiplies a symmetric 3x3 inverse matrix by a complex error vector, scales
// by 0.75 and accumulates into three stored complex coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry one matrix (six distinct entries)
//   and one complex error vector per transaction. Output channel: o_valid /
//   i_stall carry the six updated coefficients, one result per input.
//   Pipeline: the product register loads at acceptance, then come the
//   sum/scale stage and the accumulate stage, which raises o_valid.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   six lanes of three multipliers each work on the item in parallel, and
//   the coefficient add is one registered step so items follow back to back.
//   Reset (synchronous, i_rst_n low) clears the coefficients and empties the
//   pipeline. When the receiver stalls, the result holds on the outputs and
//   the two internal stages keep filling; o_stall rises once all stages
//   hold a transaction.
// ----------------------------------------------------------------------------
module complex_coeff_update_3x3 #(
    parameter int FRAC_BITS = ccu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = ccu_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ccu_pkg::FIELD_W-1:0] i_inv_11,
    input  logic [ccu_pkg::FIELD_W-1:0] i_inv_12,
    input  logic [ccu_pkg::FIELD_W-1:0] i_inv_13,
    input  logic [ccu_pkg::FIELD_W-1:0] i_inv_22,
    input  logic [ccu_pkg::FIELD_W-1:0] i_inv_23,
    input  logic [ccu_pkg::FIELD_W-1:0] i_inv_33,
    input  logic [ccu_pkg::FIELD_W-1:0] i_err_1_re,
    input  logic [ccu_pkg::FIELD_W-1:0] i_err_1_im,
    input  logic [ccu_pkg::FIELD_W-1:0] i_err_2_re,
    input  logic [ccu_pkg::FIELD_W-1:0] i_err_2_im,
    input  logic [ccu_pkg::FIELD_W-1:0] i_err_3_re,
    input  logic [ccu_pkg::FIELD_W-1:0] i_err_3_im,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ccu_pkg::FIELD_W-1:0] o_coef_1_re,
    output logic [ccu_pkg::FIELD_W-1:0] o_coef_1_im,
    output logic [ccu_pkg::FIELD_W-1:0] o_coef_3_re,
    output logic [ccu_pkg::FIELD_W-1:0] o_coef_3_im,
    output logic [ccu_pkg::FIELD_W-1:0] o_coef_5_re,
    output logic [ccu_pkg::FIELD_W-1:0] o_coef_5_im
);
    import ccu_pkg::*;

    logic signed [WORD_BITS-1:0] w_mat    [NUM_TAPS][NUM_TAPS];
    logic signed [WORD_BITS-1:0] w_err_re [NUM_TAPS];
    logic signed [WORD_BITS-1:0] w_err_im [NUM_TAPS];
    logic signed [WORD_BITS-1:0] w_delta  [NUM_LANES];
    logic [FIELD_W-1:0]          w_coef   [NUM_LANES];

    t_pipe_ctrl w_ctrl;
    logic       w_out_free;
    logic       w_adv_sum;
    logic       w_adv_mul;
    logic       w_accept;
    logic       w_load;
    logic       r_v_mul, n_v_mul;
    logic       r_v_sum, n_v_sum;
    logic       r_v_out, n_v_out;

    // Wrap inputs to the working word and mirror the symmetric entries
    always_comb begin
        w_mat[0][0] = i_inv_11[WORD_BITS-1:0];
        w_mat[0][1] = i_inv_12[WORD_BITS-1:0];
        w_mat[0][2] = i_inv_13[WORD_BITS-1:0];
        w_mat[1][1] = i_inv_22[WORD_BITS-1:0];
        w_mat[1][2] = i_inv_23[WORD_BITS-1:0];
        w_mat[2][2] = i_inv_33[WORD_BITS-1:0];
        w_mat[1][0] = w_mat[0][1];
        w_mat[2][0] = w_mat[0][2];
        w_mat[2][1] = w_mat[1][2];
        w_err_re[0] = i_err_1_re[WORD_BITS-1:0];
        w_err_im[0] = i_err_1_im[WORD_BITS-1:0];
        w_err_re[1] = i_err_2_re[WORD_BITS-1:0];
        w_err_im[1] = i_err_2_im[WORD_BITS-1:0];
        w_err_re[2] = i_err_3_re[WORD_BITS-1:0];
        w_err_im[2] = i_err_3_im[WORD_BITS-1:0];
    end

    // Advance each stage when the stage after it is empty or draining
    always_comb begin
        w_out_free    = !r_v_out || !i_stall;
        w_adv_sum     = !r_v_sum || w_out_free;
        w_adv_mul     = !r_v_mul || w_adv_sum;
        w_accept      = i_valid && w_adv_mul;
        w_load        = r_v_sum && w_out_free;
        w_ctrl.en_mul = w_accept;
        w_ctrl.en_sum = r_v_mul && w_adv_sum;
        n_v_mul       = w_accept || (r_v_mul && !w_adv_sum);
        n_v_sum       = w_ctrl.en_sum || (r_v_sum && !w_out_free);
        n_v_out       = w_load || (r_v_out && i_stall);
    end

    // Hold the stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
            r_v_sum <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            r_v_mul <= n_v_mul;
            r_v_sum <= n_v_sum;
            r_v_out <= n_v_out;
        end
    end

    assign o_stall = !w_adv_mul;
    assign o_valid = r_v_out;

    // One lane per coefficient: lane k uses row k/2, real part on even lanes
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        localparam int ROW = k / 2;
        localparam bit IMAG = (k % 2) == 1;

        logic signed [WORD_BITS-1:0] w_lane_err [NUM_TAPS];

        // Pick the real or imaginary error taps for this lane
        always_comb begin
            for (int j = 0; j < NUM_TAPS; j++) begin
                w_lane_err[j] = IMAG ? w_err_im[j] : w_err_re[j];
            end
        end

        ccu_lane #(
            .FRAC_BITS (FRAC_BITS),
            .WORD_BITS (WORD_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_row   (w_mat[ROW]),
            .i_err   (w_lane_err),
            .o_delta (w_delta[k])
        );
    end

    // Combine lane deltas into the coefficient set
    ccu_merge #(
        .WORD_BITS (WORD_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_delta (w_delta),
        .o_coef  (w_coef)
    );

    assign o_coef_1_re = w_coef[0];
    assign o_coef_1_im = w_coef[1];
    assign o_coef_3_re = w_coef[2];
    assign o_coef_3_im = w_coef[3];
    assign o_coef_5_re = w_coef[4];
    assign o_coef_5_im = w_coef[5];

endmodule
